// File: rtl/sdcd_pkg.sv
`default_nettype none

package sdcd_pkg;

  // field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 12;
  localparam int unsigned LinkW  = 15;
  localparam int unsigned NibW   = 4;
  localparam int unsigned PhaseW = 2;

  // default sizes
  localparam int unsigned DefDictDepth = 4096;
  localparam int unsigned DefMaxString = 29;

  // chain terminator
  localparam logic [LinkW-1:0] NoLink = 15'h7FFF;

  // unpacking phase codes
  localparam logic [PhaseW-1:0] PhFirst  = 2'd0;
  localparam logic [PhaseW-1:0] PhSecond = 2'd1;
  localparam logic [PhaseW-1:0] PhThird  = 2'd2;

  // item kinds
  localparam logic ActDecode = 1'b0;
  localparam logic ActWrite  = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StEmit
  } sdcd_state_e;

  typedef struct packed {
    logic take;
    logic walk;
    logic emit;
  } sdcd_cmd_t;

  typedef struct packed {
    logic walk_start;
    logic walk_end;
    logic emit_end;
  } sdcd_status_t;

endpackage

`default_nettype wire

// File: rtl/static_dictionary_code_decoder.sv
// Decodes a packed byte stream of 12-bit codes (three bytes make two codes,
// high bits first) against a loaded dictionary and emits one character per
// result item in forward order, with last_of_code on the final character
// and chain_cut on every character of a code whose chain was longer than
// MAX_STRING. Load entries with action 1 before decoding codes that use
// them; entries are not cleared by reset. A load item or a byte that does
// not complete a code does not stall the input. A completed code below
// DICT_DEPTH keeps the input stalled while its chain is walked and its
// characters are emitted, and longer while the output is stalled: the
// dictionary ram has one read port, so the link walk moves one entry per
// cycle, and the output register takes one character per cycle while the
// output is not stalled. The last result may still wait in the output
// register while the next item is accepted.
`default_nettype none

module static_dictionary_code_decoder
  import sdcd_pkg::*;
#(
  parameter int unsigned DICT_DEPTH = DefDictDepth,
  parameter int unsigned MAX_STRING = DefMaxString
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // input item channel
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             action_i,
  input  wire logic [ByteW-1:0] data_byte_i,
  input  wire logic             first_of_buffer_i,
  input  wire logic [CodeW-1:0] entry_index_i,
  input  wire logic [LinkW-1:0] entry_link_i,
  input  wire logic [ByteW-1:0] entry_char_i,
  // result item channel
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [ByteW-1:0]      out_char_o,
  output logic                  last_of_code_o,
  output logic                  chain_cut_o
);

  sdcd_cmd_t    cmd;
  sdcd_status_t status;

  // sequencer: idle, link walk, emit
  sdcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // unpacker, dictionary ram, reverse stack and output register
  sdcd_datapath #(
    .DICT_DEPTH (DICT_DEPTH),
    .MAX_STRING (MAX_STRING)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .in_valid_i        (in_valid_i),
    .action_i          (action_i),
    .data_byte_i       (data_byte_i),
    .first_of_buffer_i (first_of_buffer_i),
    .entry_index_i     (entry_index_i),
    .entry_link_i      (entry_link_i),
    .entry_char_i      (entry_char_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_char_o        (out_char_o),
    .last_of_code_o    (last_of_code_o),
    .chain_cut_o       (chain_cut_o)
  );

  // a completed code must hold off the next item
  a_walk_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.take && status.walk_start) |=> in_stall_o)
    else $error("input not stalled after a code started its walk");

  // a new result only ever comes from the emit phase
  a_emit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.emit))
    else $error("result appeared outside the emit phase");

  // the input is open only while the sequencer is idle
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (!cmd.walk && !cmd.emit))
    else $error("input open during walk or emit");

endmodule

`default_nettype wire

// File: rtl/sdcd_ctrl.sv
`default_nettype none

module sdcd_ctrl
  import sdcd_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire sdcd_status_t status_i,
  output sdcd_cmd_t         cmd_o
);

  sdcd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        cmd_o.take = in_valid_i;
        if (in_valid_i && status_i.walk_start) begin
          state_d = StWalk;
        end
      end
      StWalk: begin
        cmd_o.walk = 1'b1;
        if (status_i.walk_end) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        cmd_o.emit = 1'b1;
        if (status_i.emit_end) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/sdcd_datapath.sv
`default_nettype none

module sdcd_datapath
  import sdcd_pkg::*;
#(
  parameter int unsigned DICT_DEPTH = DefDictDepth,
  parameter int unsigned MAX_STRING = DefMaxString
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sdcd_cmd_t        cmd_i,
  output sdcd_status_t          status_o,
  input  wire logic             in_valid_i,
  input  wire logic             action_i,
  input  wire logic [ByteW-1:0] data_byte_i,
  input  wire logic             first_of_buffer_i,
  input  wire logic [CodeW-1:0] entry_index_i,
  input  wire logic [LinkW-1:0] entry_link_i,
  input  wire logic [ByteW-1:0] entry_char_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [ByteW-1:0]      out_char_o,
  output logic                  last_of_code_o,
  output logic                  chain_cut_o
);

  localparam int unsigned AW = $clog2(DICT_DEPTH);
  localparam int unsigned SW = $clog2(MAX_STRING);
  localparam int unsigned DW = $clog2(MAX_STRING + 1);
  localparam int unsigned EW = LinkW + ByteW;
  localparam logic [DW-1:0]    LastDepth = DW'(MAX_STRING - 1);
  localparam logic [CodeW:0]   IdxLimit  = (CodeW + 1)'(DICT_DEPTH);
  localparam logic [LinkW-1:0] LinkLimit = LinkW'(DICT_DEPTH);

  // dictionary ram, {link, char}
  logic [EW-1:0] dict_mem [DICT_DEPTH];
  logic [EW-1:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;

  // unpacker
  logic [PhaseW-1:0] phase_q, phase_d, phase_eff;
  logic [ByteW-1:0]  high_q, high_d;
  logic [NibW-1:0]   nib_q, nib_d;
  logic [CodeW-1:0]  code;
  logic              code_ok;

  // walk and emit
  logic [ByteW-1:0] stack_q [MAX_STRING];
  logic [DW-1:0]    depth_q, depth_d, depth_m1;
  logic [DW-1:0]    stop_q, stop_d;
  logic             cut_q, cut_d;
  logic [LinkW-1:0] rd_link;
  logic [ByteW-1:0] rd_char;
  logic             link_more;
  logic             slot_free, emit_fire;
  logic             decode_take;

  assign rd_link = rd_q[EW-1:ByteW];
  assign rd_char = rd_q[ByteW-1:0];
  assign link_more = (rd_link != NoLink) && (rd_link < LinkLimit);
  assign depth_m1 = depth_q - DW'(1);
  assign decode_take = cmd_i.take && (action_i == ActDecode);
  assign wr_en = cmd_i.take && (action_i == ActWrite) && ({1'b0, entry_index_i} < IdxLimit);

  // code assembly: three bytes hold two codes
  always_comb begin
    phase_eff = first_of_buffer_i ? PhFirst : phase_q;
    phase_d   = phase_q;
    high_d    = high_q;
    nib_d     = nib_q;
    code      = '0;
    code_ok   = 1'b0;
    unique case (phase_eff)
      PhSecond: begin
        code    = {high_q, data_byte_i[ByteW-1:NibW]};
        code_ok = 1'b1;
        nib_d   = data_byte_i[NibW-1:0];
        phase_d = PhThird;
      end
      PhThird: begin
        code    = {nib_q, data_byte_i};
        code_ok = 1'b1;
        nib_d   = '0;
        phase_d = PhFirst;
      end
      default: begin
        high_d  = data_byte_i;
        phase_d = PhSecond;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFirst;
      high_q  <= '0;
      nib_q   <= '0;
    end else if (decode_take) begin
      phase_q <= phase_d;
      high_q  <= high_d;
      nib_q   <= nib_d;
    end
  end

  assign status_o.walk_start = in_valid_i && (action_i == ActDecode) && code_ok
                               && ({1'b0, code} < IdxLimit);

  // next link is read straight from the registered entry
  assign rd_addr = cmd_i.walk ? rd_link[AW-1:0] : code[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      dict_mem[entry_index_i[AW-1:0]] <= {entry_link_i, entry_char_i};
    end
    rd_q <= dict_mem[rd_addr];
  end

  assign status_o.walk_end = !link_more || (depth_q == LastDepth);

  // walk pushes one char per cycle, emit pops one per cycle while the output slot is free
  assign slot_free = !out_valid_o || !out_stall_i;
  assign status_o.emit_end = (depth_q == stop_q);
  assign emit_fire = cmd_i.emit && !status_o.emit_end && slot_free;

  always_comb begin
    depth_d = depth_q;
    stop_d  = stop_q;
    cut_d   = cut_q;
    if (cmd_i.take && status_o.walk_start) begin
      depth_d = '0;
      stop_d  = '0;
      cut_d   = 1'b0;
    end else if (cmd_i.walk) begin
      depth_d = depth_q + DW'(1);
      // emission ends before the deepest zero char
      if (rd_char == '0) begin
        stop_d = depth_q + DW'(1);
      end
      cut_d = link_more && (depth_q == LastDepth);
    end else if (emit_fire) begin
      depth_d = depth_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      stop_q  <= '0;
      cut_q   <= 1'b0;
    end else begin
      depth_q <= depth_d;
      stop_q  <= stop_d;
      cut_q   <= cut_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk) begin
      stack_q[depth_q[SW-1:0]] <= rd_char;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (emit_fire) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_char_o     <= stack_q[depth_m1[SW-1:0]];
      last_of_code_o <= (depth_m1 == stop_q);
      chain_cut_o    <= cut_q;
    end
  end

endmodule

`default_nettype wire
